// ----- rtl/core/scs_pkg.sv -----
// shared types, constants and helpers for the spherical/cartesian converter
// depends on nothing; used by scs_cell, scs_gain and the top level
package scs_pkg;

  localparam int CORDIC_STAGES = 24;
  localparam int STEP_W = 5;
  localparam int V_W = 36;
  localparam int A_W = 35;

  localparam logic signed [A_W-1:0] PI_Q30 = 35'sd3373259426;
  localparam logic signed [A_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [A_W-1:0] TWO_PI_Q30 = 35'sd6746518852;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [V_W-1:0] Q_MAX = 36'sd2147483647;
  localparam logic signed [V_W-1:0] Q_MIN = -36'sd2147483648;

  localparam logic [29:0] ATAN_TABLE [32] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000007, 30'h00000003, 30'h00000001,
    30'h00000000, 30'h00000000
  };

  // data that rides along with each item
  typedef struct packed {
    logic                  valid;
    logic                  req;
    logic                  neg;
    logic                  zero;
    logic signed [A_W-1:0] ang;
    logic signed [V_W-1:0] keep;
  } side_t;

  // one pipeline slot
  typedef struct packed {
    side_t                 side;
    logic signed [V_W-1:0] x;
    logic signed [V_W-1:0] y;
    logic signed [A_W-1:0] z;
  } stage_t;

  typedef struct packed {
    logic                  neg;
    logic signed [A_W-1:0] z;
  } rot_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } sat_t;

  function automatic logic signed [A_W-1:0] atan_angle(input logic [STEP_W-1:0] i);
    return signed'({5'b00000, ATAN_TABLE[i]});
  endfunction

  // q3.28 angle to internal q30, folded into [-pi/2, pi/2] with negate flag
  function automatic rot_t wrap_angle(input logic signed [31:0] a);
    logic signed [A_W-1:0] z;
    rot_t r;
    z = {a[31], a, 2'b00};
    r.neg = 1'b0;
    if (z > PI_Q30) z = z - TWO_PI_Q30;
    if (z < -PI_Q30) z = z + TWO_PI_Q30;
    if (z > HALF_PI_Q30) begin
      z = z - PI_Q30;
      r.neg = 1'b1;
    end else if (z < -HALF_PI_Q30) begin
      z = z + PI_Q30;
      r.neg = 1'b1;
    end
    r.z = z;
    return r;
  endfunction

  // clamp to signed 32 bits
  function automatic sat_t saturate(input logic signed [V_W-1:0] v);
    sat_t s;
    s.ovf = 1'b0;
    s.val = v[31:0];
    if (v > Q_MAX) begin
      s.ovf = 1'b1;
      s.val = Q_MAX[31:0];
    end else if (v < Q_MIN) begin
      s.ovf = 1'b1;
      s.val = Q_MIN[31:0];
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/scs_cell.sv -----
// one cordic micro-rotation, rotation or vectoring chosen per item
// depends on scs_pkg
module scs_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [scs_pkg::STEP_W-1:0]    step,
  input  scs_pkg::stage_t               din,
  output scs_pkg::stage_t               dout
);

  logic signed [scs_pkg::V_W-1:0] sx;
  logic signed [scs_pkg::V_W-1:0] sy;
  logic signed [scs_pkg::A_W-1:0] ang;
  logic                           turn;
  scs_pkg::stage_t                dout_next;

  assign sx  = din.x >>> step;
  assign sy  = din.y >>> step;
  assign ang = scs_pkg::atan_angle(step);

  // vectoring steers on the sign of y, rotation on the residual angle
  assign turn = din.side.req ? din.y[scs_pkg::V_W-1] : !din.z[scs_pkg::A_W-1];

  always_comb begin
    dout_next = din;
    if (turn) begin
      dout_next.x = din.x - sy;
      dout_next.y = din.y + sx;
      dout_next.z = din.z - ang;
    end else begin
      dout_next.x = din.x + sy;
      dout_next.y = din.y - sx;
      dout_next.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dout <= '0;
    else     dout <= dout_next;
  end

endmodule

// ----- rtl/core/scs_gain.sv -----
// two-stage cordic gain compensation of x and y, truncating toward zero
// depends on scs_pkg
module scs_gain (
  input  logic            clk,
  input  logic            rst,
  input  scs_pkg::stage_t din,
  output scs_pkg::stage_t dout
);

  logic [scs_pkg::V_W-1:0] mag_x;
  logic [scs_pkg::V_W-1:0] mag_y;
  logic                    sgn_x;
  logic                    sgn_y;
  logic [47:0]             lo_x;
  logic [47:0]             hi_x;
  logic [47:0]             lo_y;
  logic [47:0]             hi_y;
  logic                    neg_x;
  logic                    neg_y;
  scs_pkg::stage_t         hold;
  logic [65:0]             sum_x;
  logic [65:0]             sum_y;
  logic [35:0]             q_x;
  logic [35:0]             q_y;
  scs_pkg::stage_t         dout_next;

  // magnitudes; a pending negation folds into the sign
  assign sgn_x = din.x[scs_pkg::V_W-1] ^ din.side.neg;
  assign sgn_y = din.y[scs_pkg::V_W-1] ^ din.side.neg;
  assign mag_x = din.x[scs_pkg::V_W-1] ? 36'(-din.x) : 36'(din.x);
  assign mag_y = din.y[scs_pkg::V_W-1] ? 36'(-din.y) : 36'(din.y);

  // partial products
  always_ff @(posedge clk) begin
    lo_x  <= 48'(mag_x[17:0]) * 48'(scs_pkg::INV_GAIN_Q30);
    hi_x  <= 48'(mag_x[35:18]) * 48'(scs_pkg::INV_GAIN_Q30);
    lo_y  <= 48'(mag_y[17:0]) * 48'(scs_pkg::INV_GAIN_Q30);
    hi_y  <= 48'(mag_y[35:18]) * 48'(scs_pkg::INV_GAIN_Q30);
    neg_x <= sgn_x;
    neg_y <= sgn_y;
    if (rst) hold <= '0;
    else     hold <= din;
  end

  // combine and restore sign
  assign sum_x = {hi_x, 18'b0} + 66'(lo_x);
  assign sum_y = {hi_y, 18'b0} + 66'(lo_y);
  assign q_x   = sum_x[65:30];
  assign q_y   = sum_y[65:30];

  always_comb begin
    dout_next          = hold;
    dout_next.side.neg = 1'b0;
    dout_next.x        = neg_x ? -signed'(q_x) : signed'(q_x);
    dout_next.y        = neg_y ? -signed'(q_y) : signed'(q_y);
  end

  always_ff @(posedge clk) begin
    if (rst) dout <= '0;
    else     dout <= dout_next;
  end

endmodule

// ----- rtl/core/spherical_cartesian_converter.sv -----
// top level: two cordic cell chains, each followed by gain compensation
// depends on scs_pkg, scs_cell and scs_gain
//
// One point is taken in every clock cycle (busy is always low). Its result
// is on the outputs, marked by done, after it has passed the input register,
// the first pass of one-stage-per-iteration cordic cells, the register between
// the passes, the second pass, two-stage gain compensation after each pass and
// the output register; the receiver cannot stall, so results must be captured
// when done is high.
module spherical_cartesian_converter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               req_type,
  input  logic signed [31:0] first_in,
  input  logic signed [31:0] second_in,
  input  logic signed [31:0] third_in,
  output logic               done,
  output logic signed [31:0] first_out,
  output logic signed [31:0] second_out,
  output logic signed [31:0] third_out,
  output logic               overflow
);

  localparam int N = scs_pkg::CORDIC_STAGES;
  localparam int LATENCY = 2 * N + 7;

  scs_pkg::stage_t p1 [0:N];
  scs_pkg::stage_t p2 [0:N];
  scs_pkg::stage_t g1;
  scs_pkg::stage_t g2;
  scs_pkg::stage_t p1_next;
  scs_pkg::stage_t p2_next;
  scs_pkg::rot_t   rot1;
  scs_pkg::rot_t   rot2;
  scs_pkg::sat_t   s_a;
  scs_pkg::sat_t   s_b;
  scs_pkg::sat_t   s_c;
  logic signed [scs_pkg::V_W-1:0] cx;
  logic signed [scs_pkg::V_W-1:0] cy;
  logic signed [scs_pkg::V_W-1:0] rho;
  logic signed [scs_pkg::A_W-1:0] lon;
  logic signed [scs_pkg::A_W-1:0] lat;
  logic signed [scs_pkg::A_W-1:0] lon_out;
  logic signed [scs_pkg::V_W-1:0] r_val;
  logic                           out_req;

  assign busy = 1'b0;

  // first pass setup
  assign rot1 = scs_pkg::wrap_angle(second_in);
  assign cx   = 36'(first_in);
  assign cy   = 36'(second_in);

  always_comb begin
    p1_next            = '0;
    p1_next.side.valid = start;
    p1_next.side.req   = req_type;
    if (!req_type) begin
      p1_next.x         = cx;
      p1_next.z         = rot1.z;
      p1_next.side.neg  = rot1.neg;
      p1_next.side.ang  = 35'(third_in);
    end else begin
      p1_next.side.zero = (first_in == 32'sd0) && (second_in == 32'sd0);
      p1_next.side.keep = 36'(third_in);
      p1_next.x         = cx;
      p1_next.y         = cy;
      if (first_in < 0) begin
        p1_next.x        = -cx;
        p1_next.y        = -cy;
        p1_next.side.ang = (second_in >= 0) ? scs_pkg::PI_Q30 : -scs_pkg::PI_Q30;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p1[0] <= '0;
    else     p1[0] <= p1_next;
  end

  // first cordic chain
  for (genvar i = 0; i < N; i++) begin : g_pass1
    scs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (scs_pkg::STEP_W'(i)),
      .din  (p1[i]),
      .dout (p1[i+1])
    );
  end

  scs_gain u_gain1 (
    .clk  (clk),
    .rst  (rst),
    .din  (p1[N]),
    .dout (g1)
  );

  // second pass setup
  assign rot2 = scs_pkg::wrap_angle(g1.side.ang[31:0]);
  assign lon  = g1.side.zero ? '0 : g1.z + g1.side.ang;
  assign rho  = g1.side.zero ? '0 : g1.x;

  always_comb begin
    p2_next            = '0;
    p2_next.side.valid = g1.side.valid;
    p2_next.side.req   = g1.side.req;
    if (!g1.side.req) begin
      p2_next.x         = g1.x;
      p2_next.z         = rot2.z;
      p2_next.side.neg  = rot2.neg;
      p2_next.side.keep = g1.y;
    end else begin
      p2_next.x         = rho;
      p2_next.y         = g1.side.keep;
      p2_next.side.ang  = lon;
      p2_next.side.zero = (rho == '0) && (g1.side.keep == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p2[0] <= '0;
    else     p2[0] <= p2_next;
  end

  // second cordic chain
  for (genvar i = 0; i < N; i++) begin : g_pass2
    scs_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .step (scs_pkg::STEP_W'(i)),
      .din  (p2[i]),
      .dout (p2[i+1])
    );
  end

  scs_gain u_gain2 (
    .clk  (clk),
    .rst  (rst),
    .din  (p2[N]),
    .dout (g2)
  );

  // result formatting
  assign r_val   = g2.side.zero ? '0 : g2.x;
  assign lat     = g2.side.zero ? '0 : g2.z;
  assign lon_out = g2.side.ang;
  assign s_a     = scs_pkg::saturate(g2.side.req ? r_val : g2.x);
  assign s_b     = scs_pkg::saturate(g2.y);
  assign s_c     = scs_pkg::saturate(g2.side.keep);

  always_ff @(posedge clk) begin
    out_req   <= g2.side.req;
    first_out <= s_a.val;
    if (g2.side.req) begin
      second_out <= 32'(lat >>> 2);
      third_out  <= 32'(lon_out >>> 2);
      overflow   <= s_a.ovf;
    end else begin
      second_out <= s_b.val;
      third_out  <= s_c.val;
      overflow   <= s_a.ovf | s_b.ovf | s_c.ovf;
    end
    if (rst) done <= 1'b0;
    else     done <= g2.side.valid;
  end

  // a result only follows a taken item, matched against start through LATENCY
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without matching item");

  // a radius is never negative
  a_radius_sign: assert property (@(posedge clk) disable iff (rst)
    done && out_req |-> !first_out[31])
    else $error("negative radius");

  // a cartesian-to-spherical overflow clamps the radius at the maximum
  a_radius_clamp: assert property (@(posedge clk) disable iff (rst)
    done && out_req && overflow |-> first_out == 32'sh7FFFFFFF)
    else $error("radius overflow without clamp");

endmodule
